// ===== rtl/core/multirate_tick_scheduler_macros.svh =====
// Assertion macros for the tick scheduler.
// Used by the top level only; no dependencies.
`ifndef MULTIRATE_TICK_SCHEDULER_MACROS_SVH
`define MULTIRATE_TICK_SCHEDULER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/mts_pkg.sv =====
// Package for the multirate tick scheduler: types and constants.
// No dependencies.
package mts_pkg;
   localparam logic [19:0] US_PER_SECOND = 20'd1000000;
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;
   localparam logic       KIND_TICK = 1'b0;
   localparam logic       KIND_ADD  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_GCD, ST_ADD_WR, ST_TICK_RD, ST_TICK_MUL, ST_TICK_CMP,
      ST_TICK_WR, ST_RESP
   } state_type;
endpackage

// ===== rtl/core/mts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/multirate_tick_scheduler.sv =====
// Multirate tick scheduler top level: sequencer, divider, gcd unit; uses mts_pkg, mts_ram.
// A refused add goes straight to the response. A stored add runs the division, the
// Euclid remainder steps (skipped for a zero period) and the table write. A tick visits
// each slot: read, multiply, compare, write back; free slots skip multiply and compare.
// One item is in work at a time; the next is taken the cycle after the response.
// Reset (synchronous, active high) clears slot-used flags and sets base to 1000000.
`include "multirate_tick_scheduler_macros.svh"
module multirate_tick_scheduler
   import mts_pkg::*;
#(
   parameter int MAX_TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] freq
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [4:2] slot,
                                    // [12:5] fire_mask, [32:13] base_period
);
   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int FW = (MAX_TASKS < 8) ? MAX_TASKS : 8;

   state_type state_ff, state_in;

   // Slot-used flags live in flip-flops so reset clears them at once.
   logic [MAX_TASKS-1:0] used_ff, used_in;
   logic [19:0] base_ff, base_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   found_w;
   logic          have_free;

   // Shared iterative unit: restoring division for the period, then
   // Euclid with bit-serial remainders for the gcd.
   logic [19:0] num_ff, num_in;    // dividend / running quotient bits
   logic [20:0] rem_ff, rem_in;    // partial remainder
   logic [19:0] den_ff, den_in;    // divisor
   logic [4:0]  bit_ff, bit_in;
   logic [19:0] period_ff, period_in;
   logic [20:0] trial;

   logic [40:0] prod_ff, prod_in;
   logic [20:0] cnt_ff, cnt_in;
   logic [7:0]  fire_ff, fire_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  slot_ff, slot_in;

   logic        pw_en, cw_en;
   logic [AW-1:0] w_addr;
   logic [19:0] pw_data, p_rd;
   logic [20:0] cw_data, c_rd;

   mts_ram #(.WIDTH(20), .DEPTH(1 << AW)) u_period (
      .clock(clock), .wr_en(pw_en), .wr_addr(w_addr), .wr_data(pw_data),
      .rd_addr(idx_ff), .rd_data(p_rd));
   mts_ram #(.WIDTH(21), .DEPTH(1 << AW)) u_count (
      .clock(clock), .wr_en(cw_en), .wr_addr(w_addr), .wr_data(cw_data),
      .rd_addr(idx_ff), .rd_data(c_rd));

   // Lowest free slot.
   always_comb begin
      found_w = '0;
      have_free = 1'b0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            found_w = (AW + 1)'(i);
            have_free = 1'b1;
         end
      end
   end

   assign trial = {rem_ff[19:0], num_ff[19]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         base_ff  <= US_PER_SECOND;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         base_ff  <= base_in;
      end
      idx_ff <= idx_in; num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      bit_ff <= bit_in; period_ff <= period_in; prod_ff <= prod_in;
      cnt_ff <= cnt_in; fire_ff <= fire_in; status_ff <= status_in;
      slot_ff <= slot_in;
   end

   always_comb begin
      state_in = state_ff; used_in = used_ff; base_in = base_ff;
      idx_in = idx_ff; num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      bit_in = bit_ff; period_in = period_ff; prod_in = prod_ff;
      cnt_in = cnt_ff; fire_in = fire_ff; status_in = status_ff;
      slot_in = slot_ff;
      pw_en = 1'b0; cw_en = 1'b0; w_addr = idx_ff;
      pw_data = period_ff; cw_data = cnt_ff;
      req_tready = 1'b0; rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            status_in = STATUS_OK; slot_in = '0; fire_in = '0;
            idx_in = '0;
            if (req_tvalid) begin
               if (req_tuser == KIND_TICK) begin
                  state_in = ST_TICK_RD;
               end else if (req_tdata[19:0] == 20'd0) begin
                  status_in = STATUS_ZERO; state_in = ST_RESP;
               end else if (!have_free) begin
                  status_in = STATUS_FULL; state_in = ST_RESP;
               end else begin
                  idx_in = found_w[AW-1:0];
                  slot_in = 3'(found_w);
                  num_in = US_PER_SECOND; den_in = req_tdata[19:0];
                  rem_in = '0; bit_in = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle.
            if (!trial[20]) begin
               rem_in = trial;
               num_in = {num_ff[18:0], 1'b1};
            end else begin
               rem_in = {rem_ff[19:0], num_ff[19]};
               num_in = {num_ff[18:0], 1'b0};
            end
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd19) begin
               period_in = num_in;
               // gcd(base, p): x = base, y = p; den holds y.
               if (num_in == 20'd0) begin
                  state_in = ST_ADD_WR;
               end else begin
                  den_in = num_in; num_in = base_ff;
                  rem_in = '0; bit_in = '0;
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            // Bit-serial x mod y; once all 20 bits of x are shifted in, rem holds the remainder.
            if (!trial[20]) begin
               rem_in = trial;
            end else begin
               rem_in = {rem_ff[19:0], num_ff[19]};
            end
            num_in = {num_ff[18:0], 1'b0};
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd19) begin
               if (rem_in == 21'd0) begin
                  base_in = den_ff;
                  state_in = ST_ADD_WR;
               end else begin
                  num_in = den_ff; den_in = rem_in[19:0];
                  rem_in = '0; bit_in = '0;
               end
            end
         end
         ST_ADD_WR: begin
            pw_en = 1'b1; cw_en = 1'b1; pw_data = period_ff; cw_data = '0;
            used_in[idx_ff] = 1'b1;
            state_in = ST_RESP;
         end
         ST_TICK_RD: begin
            // Memory read of slot idx is under way.
            state_in = used_ff[idx_ff] ? ST_TICK_MUL : ST_TICK_WR;
         end
         ST_TICK_MUL: begin
            cnt_in = c_rd + 21'd1;
            period_in = p_rd;
            prod_in = 41'(cnt_in) * 41'(base_ff);
            state_in = ST_TICK_CMP;
         end
         ST_TICK_CMP: begin
            if (prod_ff >= 41'(period_ff)) begin
               cnt_in = '0;
               if (32'(idx_ff) < 32'(FW)) begin
                  fire_in[3'(idx_ff)] = 1'b1;
               end
            end
            state_in = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            cw_en = used_ff[idx_ff];
            if (32'(idx_ff) == MAX_TASKS - 1) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_TICK_RD;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {7'd0, base_ff, fire_ff, slot_ff, status_ff};

   `MTS_ASSERT_IMP(a_base_nonzero, clock, reset, 1'b1, base_ff != 20'd0, "base period zero")
   `MTS_ASSERT_IMP(a_ready_idle, clock, reset, rsp_tvalid, !req_tready, "ready during response")
   `MTS_ASSERT_NXT(a_used_grow, clock, reset, 1'b1, (used_ff & $past(used_ff)) == $past(used_ff),
      "slot freed")
endmodule

// ===== sim/multirate_tick_scheduler_checker.sv =====
// Checker for the multirate tick scheduler: watches both channels, predicts
// each response from accepted requests and compares the whole word.
// Depends on mts_pkg.
`timescale 1ns / 100ps
module multirate_tick_scheduler_checker
   import mts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   typedef struct packed {
      logic [19:0] base_period;
      logic [7:0]  fire_mask;
      logic [2:0]  slot;
      logic [1:0]  status;
   } sched_rsp_type;

   localparam int NUM_SLOTS = 8;

   logic          slot_taken [NUM_SLOTS];
   logic [19:0]   slot_period [NUM_SLOTS];
   logic [20:0]   slot_ticks [NUM_SLOTS];
   logic [19:0]   base_tick;
   sched_rsp_type expected_rsp_q[$];

   function automatic logic [19:0] gcd20(logic [19:0] a, logic [19:0] b);
      logic [19:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Advances the schedule table by one request and returns the response.
   function automatic sched_rsp_type schedule_step(logic kind, logic [19:0] freq);
      sched_rsp_type r;
      int found;
      logic [19:0] p;
      logic [40:0] wait_us;
      r = '0;
      found = -1;
      if (kind == KIND_ADD) begin
         if (freq == 0) begin
            r.status = STATUS_ZERO;
         end else begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
               if (!slot_taken[i]) found = i;
            if (found < 0) begin
               r.status = STATUS_FULL;
            end else begin
               p = 20'(32'(US_PER_SECOND) / 32'(freq));
               slot_taken[found] = 1'b1;
               slot_period[found] = p;
               slot_ticks[found] = '0;
               base_tick = gcd20(base_tick, p);
               r.status = STATUS_OK;
               r.slot = 3'(found);
            end
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_taken[i]) begin
               slot_ticks[i] = slot_ticks[i] + 1'b1;
               wait_us = 41'(slot_ticks[i]) * 41'(base_tick);
               if (wait_us >= 41'(slot_period[i])) begin
                  slot_ticks[i] = '0;
                  r.fire_mask[i] = 1'b1;
               end
            end
         end
      end
      r.base_period = base_tick;
      return r;
   endfunction

   // The table is updated with blocking assignments as each request is predicted.
   always @(posedge clock) begin
      sched_rsp_type got, want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_taken[i] = 1'b0;
            slot_period[i] = '0;
            slot_ticks[i] = '0;
         end
         base_tick = US_PER_SECOND;
         expected_rsp_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(schedule_step(req_tuser, req_tdata[19:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[32:0];
            if (expected_rsp_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected response %h", rsp_tdata);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got !== want || rsp_tdata[39:33] !== '0) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: status %0d/%0d slot %0d/%0d fire %h/%h base %0d/%0d",
                        want.status, got.status, want.slot, got.slot,
                        want.fire_mask, got.fire_mask, want.base_period, got.base_period);
               end
            end
         end
         pending_count <= expected_rsp_q.size();
      end
   end
endmodule

// ===== sim/multirate_tick_scheduler_tb.sv =====
// Testbench top for the multirate tick scheduler: clock, reset, request and
// response stimulus, verdict. Depends on mts_pkg, the block and its checker.
`timescale 1ns / 100ps
module multirate_tick_scheduler_tb
   import mts_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [19:0] freq
   logic        req_tuser = 1'b0;  // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [1:0] status, [4:2] slot, [12:5] fire, [32:13] base
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          steady_phase = 1'b0;

   always #4 clock = ~clock;

   multirate_tick_scheduler DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   multirate_tick_scheduler_checker checker_inst (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending_count
   );

   // The receiver stalls at random about 37 percent of the time, except in a steady stretch.
   always @(posedge clock)
      rsp_tready <= !reset && (steady_phase || $urandom_range(99) >= 37);

   // Watchdog: counts cycles in which no handshake occurs on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("multirate_tick_scheduler regression: fail");
         $finish;
      end
   end

   // Drives one item and holds it until it is accepted. Random gaps come first;
   // valid stays high after acceptance until the next call drives it.
   task automatic send_item(logic kind, logic [19:0] freq);
      if (!steady_phase && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (!steady_phase && $urandom_range(99) < 37) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Draws a frequency: mostly divisors-friendly values, sometimes anything.
   function automatic logic [19:0] pick_freq();
      case ($urandom_range(5))
         0: return 20'($urandom_range(1, 20));
         1: return 20'($urandom_range(1, 2000));
         2: return 20'($urandom_range(1, 1000000));
         3: return 20'($urandom);
         4: return 20'(10 ** $urandom_range(0, 6));
         default: return 20'($urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero frequency, tick on an empty table, extremes,
      // frequency above one million, then filling the table to overflow.
      send_item(KIND_ADD, 20'd0);
      send_item(KIND_TICK, 20'hFFFFF);
      send_item(KIND_ADD, 20'd1);
      send_item(KIND_ADD, 20'd1000000);
      send_item(KIND_ADD, 20'hFFFFF);
      send_item(KIND_TICK, 20'd0);
      send_item(KIND_ADD, 20'd3);
      send_item(KIND_ADD, 20'd7);
      send_item(KIND_ADD, 20'd999999);
      send_item(KIND_ADD, 20'd2);
      send_item(KIND_ADD, 20'd5);
      send_item(KIND_ADD, 20'd11);
      send_item(KIND_ADD, 20'd0);
      for (int i = 0; i < 6; i++) send_item(KIND_TICK, 20'($urandom));

      // Random part. The table fills for good after eight adds and the block is never reset
      // again; the directed part filled it, so random adds are refused and ticks run deeply.
      for (int n = 0; n < 800; n++) begin
         steady_phase = (n >= 300 && n < 420);
         if ($urandom_range(99) < 20)
            send_item(KIND_ADD, pick_freq());
         else
            send_item(KIND_TICK, 20'($urandom));
      end
      req_tvalid <= 1'b0;
      steady_phase = 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("multirate_tick_scheduler regression: pass");
      else
         $display("multirate_tick_scheduler regression: fail");
      $finish;
   end
endmodule
